// ===== sv/button_layer_event_scanner_defines.svh =====
// assertion macros for the button layer event scanner
// used by modules that carry concurrent checks, no other dependencies
`ifndef BUTTON_LAYER_EVENT_SCANNER_DEFINES_SVH
`define BUTTON_LAYER_EVENT_SCANNER_DEFINES_SVH

`ifndef SYNTH
`define BLES_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");
`define BLES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");
`else
`define BLES_ASSERT(name, clk, rst_n, ante, cons)
`define BLES_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bles_pkg.sv =====
// types and constants shared by the button layer event scanner
// no dependencies
package bles_pkg;

    localparam int NUM_BUTTONS = 13;
    localparam int BTN_IDX_W   = 4;
    localparam int HOLD_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    localparam logic [NUM_BUTTONS-1:0] RST_ACTIVE_LOW_MASK = 13'd8191;
    localparam logic                   RST_POWER_ACTIVE_LOW = 1'b1;
    localparam logic [NUM_BUTTONS-1:0] RST_NORMAL_MASK     = 13'd8191;
    localparam logic [NUM_BUTTONS-1:0] RST_SPECIAL_MASK    = 13'd2319;
    localparam logic [NUM_BUTTONS-1:0] RST_SYSRQ_MASK      = 13'd2063;
    localparam logic [BTN_IDX_W-1:0]   RST_ALT_INDEX       = 4'd10;
    localparam logic [HOLD_W-1:0]      RST_LONG_PRESS      = 16'd100;
    localparam logic [HOLD_W-1:0]      RST_POWEROFF        = 16'd250;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW_MASK  = 3'd0,
        CFG_POWER_ACTIVE_LOW = 3'd1,
        CFG_NORMAL_MASK      = 3'd2,
        CFG_SPECIAL_MASK     = 3'd3,
        CFG_SYSRQ_MASK       = 3'd4,
        CFG_ALT_INDEX        = 3'd5,
        CFG_LONG_PRESS       = 3'd6,
        CFG_POWEROFF         = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KIND_NORMAL   = 3'd0,
        KIND_SPECIAL  = 3'd1,
        KIND_SYSRQ    = 3'd2,
        KIND_TAP      = 3'd3,
        KIND_POWEROFF = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        LAYER_NORMAL  = 2'd0,
        LAYER_SPECIAL = 2'd1,
        LAYER_SYSRQ   = 2'd2
    } t_layer;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] raw_buttons;
        logic                   raw_power;
    } t_in_word;

    typedef struct packed {
        t_kind                event_kind;
        logic [BTN_IDX_W-1:0] button;
        logic                 pressed;
        logic                 last;
    } t_out_word;

    typedef struct packed {
        logic   accept;
        t_layer layer;
    } t_lane_ctl;

    typedef struct packed {
        logic accept;
        logic slider_on;
        logic alt;
        logic any_pressed;
    } t_hold_ctl;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] events;
        logic [NUM_BUTTONS-1:0] levels;
        t_kind                  kind;
        logic                   tap;
        logic                   off;
    } t_job;

endpackage

// ===== sv/bles_lane.sv =====
// one button lane: polarity correction, per-layer seen state, change detect
// depends on bles_pkg
module bles_lane
    import bles_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_raw,
    input  logic      i_active_low,
    input  logic      i_normal_en,
    input  logic      i_special_en,
    input  logic      i_sysrq_en,
    input  t_lane_ctl i_ctl,
    output logic      o_level,
    output logic      o_event
);

    logic r_normal_seen;
    logic r_special_seen;
    logic r_sysrq_seen;

    assign o_level = i_raw ^ i_active_low;

    always_comb begin
        unique case (i_ctl.layer)
            LAYER_NORMAL:  o_event = (o_level ^ r_normal_seen) & i_normal_en;
            LAYER_SPECIAL: o_event = (o_level ^ r_special_seen) & i_special_en;
            LAYER_SYSRQ:   o_event = (o_level ^ r_sysrq_seen) & o_level & i_sysrq_en;
            default:       o_event = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_seen  <= 1'b0;
            r_special_seen <= 1'b0;
            r_sysrq_seen   <= 1'b0;
        end else if (i_ctl.accept) begin
            case (i_ctl.layer)
                LAYER_NORMAL:  r_normal_seen  <= o_level;
                LAYER_SPECIAL: r_special_seen <= o_level;
                LAYER_SYSRQ:   r_sysrq_seen   <= o_level;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/bles_hold.sv =====
// slider hold counter with power tap and power-off thresholds
// depends on bles_pkg
module bles_hold
    import bles_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hold_ctl         i_ctl,
    input  logic [HOLD_W-1:0] i_long_press,
    input  logic [HOLD_W-1:0] i_poweroff,
    output logic              o_tap,
    output logic              o_off
);

    logic              r_was_on;
    logic [HOLD_W-1:0] r_count;
    logic              n_was_on;
    logic [HOLD_W-1:0] n_count;

    always_comb begin
        n_was_on = r_was_on;
        n_count  = r_count;
        o_tap    = 1'b0;
        o_off    = 1'b0;
        if (!i_ctl.slider_on) begin
            n_count  = '0;
            n_was_on = 1'b0;
        end else if (i_ctl.alt) begin
            n_count = '0;
        end else begin
            if (!r_was_on) begin
                n_count = HOLD_W'(1);
            end else if (r_count != '0) begin
                o_tap = (r_count == i_long_press);
                o_off = (r_count == i_poweroff);
                if (r_count != HOLD_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
            if (i_ctl.any_pressed) begin
                n_count = '0;
            end
            n_was_on = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_on <= 1'b0;
            r_count  <= '0;
        end else if (i_ctl.accept) begin
            r_was_on <= n_was_on;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/bles_merge.sv =====
// merges lane events into ascending results, then tap and power-off
// depends on bles_pkg and the scanner assertion macros
`include "button_layer_event_scanner_defines.svh"

module bles_merge
    import bles_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load_en,
    input  t_job      i_load,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    output logic      o_busy
);

    logic [NUM_BUTTONS-1:0] r_pend;
    logic [NUM_BUTTONS-1:0] r_levels;
    t_kind                  r_kind;
    logic                   r_tap;
    logic                   r_off;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    logic [NUM_BUTTONS-1:0] w_low;
    logic [NUM_BUTTONS-1:0] w_rest;
    logic [BTN_IDX_W-1:0]   w_idx;
    logic                   w_active;
    logic                   w_step;
    t_out_word              w_res;

    assign w_low    = r_pend & (~r_pend + 1'b1);
    assign w_rest   = r_pend & ~w_low;
    assign w_active = (r_pend != '0) | r_tap | r_off;
    assign w_step   = w_active & (!r_out_valid | !i_out_stall);

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (w_low[i]) begin
                w_idx = w_idx | BTN_IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (r_pend != '0) begin
            w_res.event_kind = r_kind;
            w_res.button     = w_idx;
            w_res.pressed    = |(r_levels & w_low);
            w_res.last       = (w_rest == '0) & !r_tap & !r_off;
        end else if (r_tap) begin
            w_res.event_kind = KIND_TAP;
            w_res.button     = '0;
            w_res.pressed    = 1'b1;
            w_res.last       = !r_off;
        end else begin
            w_res.event_kind = KIND_POWEROFF;
            w_res.button     = '0;
            w_res.pressed    = 1'b1;
            w_res.last       = 1'b1;
        end
    end

    assign o_busy = w_active & !(w_step & w_res.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_tap  <= 1'b0;
            r_off  <= 1'b0;
        end else if (i_load_en) begin
            r_pend <= i_load.events;
            r_tap  <= i_load.tap;
            r_off  <= i_load.off;
        end else if (w_step) begin
            if (r_pend != '0) begin
                r_pend <= w_rest;
            end else if (r_tap) begin
                r_tap <= 1'b0;
            end else begin
                r_off <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_levels <= i_load.levels;
            r_kind   <= i_load.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `BLES_ASSERT(a_low_onehot, i_clk, i_rst_n, r_pend != '0, $onehot(w_low))
    `BLES_ASSERT(a_load_when_free, i_clk, i_rst_n, i_load_en, !w_active || (w_step && w_res.last))
    `BLES_ASSERT_NEXT(a_step_fills_out, i_clk, i_rst_n, w_step, r_out_valid)
    `BLES_ASSERT_NEXT(a_step_drains, i_clk, i_rst_n, w_step && !i_load_en && r_pend != '0, $countones(r_pend) + 1 == $countones($past(r_pend)))

endmodule

// ===== sv/button_layer_event_scanner.sv =====
// Button layer event scanner: one scan word per tick gives zero to fifteen event words.
// A scan word is accepted in any cycle in which the previous word's events are gone from
// the merge stage or its last event moves into the output register in that cycle. The
// merge stage puts out one event per cycle, unless the output is stalled, in ascending
// button order followed by the power tap and the power-off request. Thirteen button lanes
// and the hold counter evaluate a whole word in the accept cycle. The configuration port
// is always ready and must be written only while no events are outstanding, which the
// block itself does not enforce.
module button_layer_event_scanner
    import bles_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [NUM_BUTTONS-1:0] r_active_low_mask;
    logic                   r_power_active_low;
    logic [NUM_BUTTONS-1:0] r_normal_mask;
    logic [NUM_BUTTONS-1:0] r_special_mask;
    logic [NUM_BUTTONS-1:0] r_sysrq_mask;
    logic [BTN_IDX_W-1:0]   r_alt_index;
    logic [HOLD_W-1:0]      r_long_press;
    logic [HOLD_W-1:0]      r_poweroff;

    logic                   w_accept;
    logic [NUM_BUTTONS-1:0] w_level;
    logic [NUM_BUTTONS-1:0] w_event;
    logic                   w_slider_on;
    logic                   w_alt;
    t_layer                 w_layer;
    t_lane_ctl              w_lane_ctl;
    t_hold_ctl              w_hold_ctl;
    logic                   w_tap;
    logic                   w_off;
    t_job                   w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low_mask  <= RST_ACTIVE_LOW_MASK;
            r_power_active_low <= RST_POWER_ACTIVE_LOW;
            r_normal_mask      <= RST_NORMAL_MASK;
            r_special_mask     <= RST_SPECIAL_MASK;
            r_sysrq_mask       <= RST_SYSRQ_MASK;
            r_alt_index        <= RST_ALT_INDEX;
            r_long_press       <= RST_LONG_PRESS;
            r_poweroff         <= RST_POWEROFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ACTIVE_LOW_MASK:  r_active_low_mask  <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_POWER_ACTIVE_LOW: r_power_active_low <= i_cfg_data[0];
                CFG_NORMAL_MASK:      r_normal_mask      <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_SPECIAL_MASK:     r_special_mask     <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_SYSRQ_MASK:       r_sysrq_mask       <= i_cfg_data[NUM_BUTTONS-1:0];
                CFG_ALT_INDEX:        r_alt_index        <= i_cfg_data[BTN_IDX_W-1:0];
                CFG_LONG_PRESS:       r_long_press       <= i_cfg_data[HOLD_W-1:0];
                CFG_POWEROFF:         r_poweroff         <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept    = i_in_valid & !o_in_stall;
    assign w_slider_on = i_in_word.raw_power ^ r_power_active_low;

    // alternate index past the last button never reads as held
    assign w_alt = (r_alt_index < BTN_IDX_W'(NUM_BUTTONS)) && w_level[r_alt_index];

    always_comb begin
        if (!w_slider_on) begin
            w_layer = LAYER_NORMAL;
        end else if (w_alt) begin
            w_layer = LAYER_SYSRQ;
        end else begin
            w_layer = LAYER_SPECIAL;
        end
    end

    assign w_lane_ctl.accept = w_accept;
    assign w_lane_ctl.layer  = w_layer;

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bles_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_raw        (i_in_word.raw_buttons[g]),
            .i_active_low (r_active_low_mask[g]),
            .i_normal_en  (r_normal_mask[g]),
            .i_special_en (r_special_mask[g]),
            .i_sysrq_en   (r_sysrq_mask[g]),
            .i_ctl        (w_lane_ctl),
            .o_level      (w_level[g]),
            .o_event      (w_event[g])
        );
    end

    assign w_hold_ctl.accept      = w_accept;
    assign w_hold_ctl.slider_on   = w_slider_on;
    assign w_hold_ctl.alt         = w_alt;
    assign w_hold_ctl.any_pressed = |w_level;

    bles_hold u_hold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_hold_ctl),
        .i_long_press (r_long_press),
        .i_poweroff   (r_poweroff),
        .o_tap        (w_tap),
        .o_off        (w_off)
    );

    always_comb begin
        w_job.events = w_event;
        w_job.levels = w_level;
        w_job.tap    = w_tap;
        w_job.off    = w_off;
        unique case (w_layer)
            LAYER_NORMAL:  w_job.kind = KIND_NORMAL;
            LAYER_SPECIAL: w_job.kind = KIND_SPECIAL;
            LAYER_SYSRQ:   w_job.kind = KIND_SYSRQ;
            default:       w_job.kind = KIND_NORMAL;
        endcase
    end

    bles_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_en   (w_accept),
        .i_load      (w_job),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_busy      (o_in_stall)
    );

endmodule
